// ----- rtl/cti_pkg.sv -----
package cti_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS = 16;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_TIME = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_END_TIME = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_POS = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_VEL = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_END_POS = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_END_VEL = 3'd5;

   // where a sample falls relative to the segment
   typedef enum logic [1:0] {
      SEG_BEFORE = 2'd0,
      SEG_INSIDE = 2'd1,
      SEG_AFTER  = 2'd2
   } seg_region_type;

   localparam int REGION_W = 2;

endpackage

// ----- rtl/cti_div.sv -----
module cti_div
   import cti_pkg::*;
#(
   parameter int DW = DATA_WIDTH,
   parameter int FB = FRAC_BITS,
   parameter int MW = REGION_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [DW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [MW-1:0] in_meta,
   output logic          out_valid,
   output logic [FB-1:0] out_quot,
   output logic [DW-1:0] out_den,
   output logic [MW-1:0] out_meta
);

   // one quotient bit per stage, restoring; numerator is below the divisor
   logic          v_ff [FB];
   logic [DW-1:0] r_ff [FB];
   logic [FB-1:0] q_ff [FB];
   logic [DW-1:0] d_ff [FB];
   logic [MW-1:0] m_ff [FB];

   for (genvar i = 0; i < FB; i++) begin : g_stage
      logic          v_prev;
      logic [DW-1:0] r_prev;
      logic [FB-1:0] q_prev;
      logic [DW-1:0] d_prev;
      logic [MW-1:0] m_prev;
      logic [DW:0]   r_shift;
      logic [DW:0]   r_diff;
      logic          q_bit;
      logic [DW-1:0] r_in;
      logic [FB-1:0] q_in;

      if (i == 0) begin : g_first
         assign v_prev = in_valid;
         assign r_prev = in_num;
         assign q_prev = '0;
         assign d_prev = in_den;
         assign m_prev = in_meta;
      end else begin : g_next
         assign v_prev = v_ff[i-1];
         assign r_prev = r_ff[i-1];
         assign q_prev = q_ff[i-1];
         assign d_prev = d_ff[i-1];
         assign m_prev = m_ff[i-1];
      end

      always_comb begin
         r_shift = {r_prev, 1'b0};
         r_diff = r_shift - {1'b0, d_prev};
         q_bit = (r_shift >= {1'b0, d_prev});
         r_in = q_bit ? r_diff[DW-1:0] : r_shift[DW-1:0];
         if (FB > 1) begin
            q_in = {q_prev[FB-2:0], q_bit};
         end else begin
            q_in = FB'(q_bit);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (enable) begin
            v_ff[i] <= v_prev;
         end
         if (enable) begin
            r_ff[i] <= r_in;
            q_ff[i] <= q_in;
            d_ff[i] <= d_prev;
            m_ff[i] <= m_prev;
         end
      end
   end

   assign out_valid = v_ff[FB-1];
   assign out_quot = q_ff[FB-1];
   assign out_den = d_ff[FB-1];
   assign out_meta = m_ff[FB-1];

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      v_ff[FB-1] && m_ff[FB-1] == MW'(SEG_INSIDE) |-> r_ff[FB-1] < d_ff[FB-1])
      else $error("divider remainder not below divisor");

endmodule

// ----- rtl/cti_herm.sv -----
module cti_herm
   import cti_pkg::*;
#(
   parameter int DW = DATA_WIDTH,
   parameter int FB = FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  logic [FB-1:0]        in_u,
   input  logic [DW-1:0]        in_dur,
   input  logic [REGION_W-1:0]  in_region,
   input  logic signed [DW-1:0] start_pos,
   input  logic signed [DW-1:0] start_vel,
   input  logic signed [DW-1:0] end_pos,
   input  logic signed [DW-1:0] end_vel,
   output logic                 out_valid,
   output logic signed [DW-1:0] out_pos,
   output logic                 out_sat
);

   localparam int AW = 2 * DW;        // wraps like the 64-bit accumulator
   localparam int MW = AW - FB;       // tangent width after scaling
   localparam int HW = FB + 3;        // basis function width
   localparam int PW = AW - FB;       // rounded position before clipping
   localparam logic signed [HW-1:0] ONE_H = HW'(1) <<< FB;
   localparam logic [AW-1:0] HALF_A = AW'(1) << (FB - 1);

   // stage 1: u^2 and tangent products
   logic                 v1_ff;
   logic [REGION_W-1:0]  g1_ff;
   logic [FB-1:0]        u1_ff, u2_1_ff;
   logic signed [AW-1:0] mv0_ff, mv1_ff;
   logic [2*FB-1:0]      uu;

   // stage 2: u^3 and scaled tangents
   logic                 v2_ff;
   logic [REGION_W-1:0]  g2_ff;
   logic [FB-1:0]        u2_ff, u2_2_ff, u3_2_ff;
   logic signed [MW-1:0] m0_2_ff, m1_2_ff;
   logic [2*FB-1:0]      uuu;
   logic signed [AW-1:0] mv0_sh, mv1_sh;

   // stage 3: basis functions
   logic                 v3_ff;
   logic [REGION_W-1:0]  g3_ff;
   logic signed [HW-1:0] h00_ff, h01_ff, h10_ff, h11_ff;
   logic signed [MW-1:0] m0_3_ff, m1_3_ff;
   logic signed [HW-1:0] e1, e2, e3, h00_in, h01_in, h10_in, h11_in;

   // stage 4: weighted terms
   logic                 v4_ff;
   logic [REGION_W-1:0]  g4_ff;
   logic signed [AW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;

   // stage 5: sum, round, clip
   logic                 v5_ff;
   logic signed [DW-1:0] pos_ff, pos_in;
   logic                 sat_ff, sat_in;
   logic [AW-1:0]        acc;
   logic signed [AW-1:0] acc_sh;
   logic signed [PW-1:0] pos_full;
   logic                 ovf;

   always_comb begin
      uu = {{FB{1'b0}}, in_u} * {{FB{1'b0}}, in_u};
      uuu = {{FB{1'b0}}, u2_1_ff} * {{FB{1'b0}}, u1_ff};
      mv0_sh = mv0_ff >>> FB;
      mv1_sh = mv1_ff >>> FB;
   end

   always_comb begin
      e1 = $signed({3'b000, u2_ff});
      e2 = $signed({3'b000, u2_2_ff});
      e3 = $signed({3'b000, u3_2_ff});
      h01_in = e2 + (e2 <<< 1) - (e3 <<< 1);
      h00_in = ONE_H - h01_in;
      h10_in = e3 - (e2 <<< 1) + e1;
      h11_in = e3 - e2;
   end

   always_comb begin
      acc = p0_ff + p1_ff + p2_ff + p3_ff + HALF_A;
      acc_sh = $signed(acc) >>> FB;
      pos_full = acc_sh[PW-1:0];
      // clipped when the bits above the result disagree with its sign
      ovf = !((&pos_full[PW-1:DW-1]) || !(|pos_full[PW-1:DW-1]));
      case (g4_ff)
         SEG_BEFORE: begin
            pos_in = start_pos;
            sat_in = 1'b0;
         end
         SEG_INSIDE: begin
            sat_in = ovf;
            if (!ovf) begin
               pos_in = pos_full[DW-1:0];
            end else if (pos_full[PW-1]) begin
               pos_in = {1'b1, {(DW-1){1'b0}}};
            end else begin
               pos_in = {1'b0, {(DW-1){1'b1}}};
            end
         end
         default: begin
            pos_in = end_pos;
            sat_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (enable) begin
         g1_ff <= in_region;
         u1_ff <= in_u;
         u2_1_ff <= uu[2*FB-1:FB];
         mv0_ff <= AW'($signed(start_vel) * $signed({1'b0, in_dur}));
         mv1_ff <= AW'($signed(end_vel) * $signed({1'b0, in_dur}));

         g2_ff <= g1_ff;
         u2_ff <= u1_ff;
         u2_2_ff <= u2_1_ff;
         u3_2_ff <= uuu[2*FB-1:FB];
         m0_2_ff <= mv0_sh[MW-1:0];
         m1_2_ff <= mv1_sh[MW-1:0];

         g3_ff <= g2_ff;
         h00_ff <= h00_in;
         h01_ff <= h01_in;
         h10_ff <= h10_in;
         h11_ff <= h11_in;
         m0_3_ff <= m0_2_ff;
         m1_3_ff <= m1_2_ff;

         g4_ff <= g3_ff;
         p0_ff <= AW'(start_pos * h00_ff);
         p1_ff <= AW'(end_pos * h01_ff);
         p2_ff <= AW'(m0_3_ff * h10_ff);
         p3_ff <= AW'(m1_3_ff * h11_ff);

         pos_ff <= pos_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_pos = pos_ff;
   assign out_sat = sat_ff;

endmodule

// ----- rtl/cubic_trajectory_interpolator.sv -----
// Cubic Hermite evaluator for one trajectory segment. Write the six segment
// registers through the csr port while no request is in flight, then stream
// time samples on req; each request gives exactly one rsp carrying the
// position (Q format, clipped to the signed range) and a clip flag in tuser.
// One request is taken every cycle while rsp is not stalled. The pipeline
// has one stage for the segment compare, one stage per quotient bit in the
// normalized-time divider, and five stages for the basis polynomials,
// products and rounding. A stalled rsp holds the whole pipeline.
module cubic_trajectory_interpolator
   import cti_pkg::*;
#(
   parameter int DATA_WIDTH_P = DATA_WIDTH,
   parameter int FRAC_BITS_P = FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [((DATA_WIDTH_P+7)/8)*8-1:0] req_tdata,  // sample_time
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [((DATA_WIDTH_P+7)/8)*8-1:0] rsp_tdata,  // position
   output logic                            rsp_tuser,  // saturated
   input  logic                            csr_we,
   input  logic [CSR_ADDR_W-1:0]           csr_addr,
   input  logic [DATA_WIDTH_P-1:0]         csr_wdata
);

   localparam int DW = DATA_WIDTH_P;
   localparam int FB = FRAC_BITS_P;
   localparam int BW = ((DATA_WIDTH_P + 7) / 8) * 8;

   logic [DW-1:0] start_time_ff, end_time_ff;
   logic [DW-1:0] start_pos_ff, start_vel_ff, end_pos_ff, end_vel_ff;

   logic                enable;
   logic [DW-1:0]       sample;
   logic                va_ff;
   logic [DW-1:0]       s_ff, dur_ff;
   logic [REGION_W-1:0] reg_ff;
   logic [DW-1:0]       dur_raw;
   seg_region_type      region_in;

   logic                dv;
   logic [FB-1:0]       du;
   logic [DW-1:0]       ddur;
   logic [REGION_W-1:0] dreg;

   logic                       hv;
   logic signed [DW-1:0]       hpos;
   logic                       hsat;

   assign enable = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;
   assign sample = req_tdata[DW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= '0;
         end_time_ff <= '0;
         start_pos_ff <= '0;
         start_vel_ff <= '0;
         end_pos_ff <= '0;
         end_vel_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_START_TIME: start_time_ff <= csr_wdata;
            CSR_END_TIME:   end_time_ff <= csr_wdata;
            CSR_START_POS:  start_pos_ff <= csr_wdata;
            CSR_START_VEL:  start_vel_ff <= csr_wdata;
            CSR_END_POS:    end_pos_ff <= csr_wdata;
            CSR_END_VEL:    end_vel_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      dur_raw = end_time_ff - start_time_ff;
      if (sample < start_time_ff) begin
         region_in = SEG_BEFORE;
      end else if (sample >= end_time_ff) begin
         region_in = SEG_AFTER;
      end else begin
         region_in = SEG_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (enable) begin
         va_ff <= req_tvalid;
      end
      if (enable) begin
         // outside the segment the divider runs on harmless operands
         if (region_in == SEG_INSIDE) begin
            s_ff <= sample - start_time_ff;
            dur_ff <= dur_raw;
         end else begin
            s_ff <= '0;
            dur_ff <= DW'(1);
         end
         reg_ff <= region_in;
      end
   end

   cti_div #(.DW(DW), .FB(FB), .MW(REGION_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (va_ff),
      .in_num    (s_ff),
      .in_den    (dur_ff),
      .in_meta   (reg_ff),
      .out_valid (dv),
      .out_quot  (du),
      .out_den   (ddur),
      .out_meta  (dreg)
   );

   cti_herm #(.DW(DW), .FB(FB)) u_herm (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (dv),
      .in_u      (du),
      .in_dur    (ddur),
      .in_region (dreg),
      .start_pos ($signed(start_pos_ff)),
      .start_vel ($signed(start_vel_ff)),
      .end_pos   ($signed(end_pos_ff)),
      .end_vel   ($signed(end_vel_ff)),
      .out_valid (hv),
      .out_pos   (hpos),
      .out_sat   (hsat)
   );

   assign rsp_tvalid = hv;
   assign rsp_tdata = BW'(hpos);
   assign rsp_tuser = hsat;

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (hpos == {1'b0, {(DW-1){1'b1}}} || hpos == {1'b1, {(DW-1){1'b0}}}))
      else $error("clip flag set but position not at a limit");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_holds_front: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(va_ff) && $stable(s_ff))
      else $error("front stage moved during stall");

endmodule
